/* hdl/magma_block_cipher_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Magma block cipher core.
// Each macro checks a property on the rising edge of clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef MAGMA_BLOCK_CIPHER_CORE_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MAGMA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("magma assertion failed: same-cycle implication");

// Next-cycle implication
`define MAGMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("magma assertion failed: next-cycle implication");

`else

`define MAGMA_ASSERT_IMPLY(label, ante, cons)
`define MAGMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/magma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_pkg
// Types, S-box table and round functions shared by the Magma cipher core.
// ----------------------------------------------------------------------------
package magma_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned NUM_KEYS   = 8;
    localparam int unsigned KEY_IDX_W  = 3;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned ROUND_W    = 5;
    localparam int unsigned ROT        = 11;

    typedef logic [31:0] word_t;
    typedef logic [3:0]  nib_t;
    typedef word_t [NUM_KEYS-1:0] key_set_t;

    // Input beat
    typedef struct packed {
        logic  func;
        word_t high_half_in;
        word_t low_half_in;
    } in_t;

    // Output beat
    typedef struct packed {
        word_t high_half_out;
        word_t low_half_out;
    } out_t;

    // Block state carried between round stages
    typedef struct packed {
        logic  dec;
        word_t hi;
        word_t lo;
    } stage_t;

    localparam logic FUNC_DECRYPT = 1'b1;

    // S-box n works on nibble n, nibble 0 being the least significant
    localparam nib_t SBOX [8][16] = '{
        '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
          4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
          4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
        '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
          4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
        '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
          4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
        '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
          4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
        '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
          4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
        '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
          4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
    };

    // Apply the eight S-boxes in parallel
    function automatic word_t sbox_layer(input word_t x);
        word_t r;
        r = '0;
        for (int n = 0; n < 8; n++)
        begin
            r[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        end
        return r;
    endfunction

    // Round function: add key, substitute, rotate left
    function automatic word_t round_mix(input word_t x, input word_t k);
        word_t s;
        s = sbox_layer(x + k);
        return {s[31-ROT:0], s[31:32-ROT]};
    endfunction

    // Key word used by encryption round r
    function automatic logic [KEY_IDX_W-1:0] key_index(input logic [ROUND_W-1:0] r);
        logic [ROUND_W-1:0] back;
        back = ROUND_W'(NUM_ROUNDS - 1) - r;
        if (r < ROUND_W'(24))
            return r[KEY_IDX_W-1:0];
        else
            return back[KEY_IDX_W-1:0];
    endfunction

endpackage

/* hdl/magma_key_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_key_regs
// Holds the eight 32-bit key words written through the config port.
// ----------------------------------------------------------------------------
module magma_key_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [magma_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  magma_pkg::word_t                     cfg_wdata,
    output magma_pkg::key_set_t                  keys
);
    import magma_pkg::*;

    key_set_t keys_reg;

    // Write the addressed key word; drop writes beyond the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= '0;
        end
        else if (cfg_wr_en && (cfg_addr < CFG_IDX_W'(NUM_KEYS)))
        begin
            keys_reg[cfg_addr[KEY_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    assign keys = keys_reg;

endmodule

/* hdl/magma_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_round
// One Feistel round and its pipeline register, with the stage valid bit.
// ----------------------------------------------------------------------------
module magma_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              vld_in,
    input  magma_pkg::stage_t data_in,
    input  magma_pkg::word_t  sub_key,
    output logic              vld_out,
    output magma_pkg::stage_t data_out
);
    import magma_pkg::*;

    logic   vld_reg;
    stage_t data_reg;
    stage_t data_next;

    // Mix the low half into the high half and swap
    always_comb
    begin
        data_next.dec = data_in.dec;
        data_next.hi  = data_in.lo;
        data_next.lo  = data_in.hi ^ round_mix(data_in.lo, sub_key);
    end

    // Advance the valid bit with the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    // Advance the block; hold it while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

/* hdl/magma_block_cipher_core.sv */
`timescale 1ns / 1ps
`include "magma_block_cipher_core_assert.svh"
// ----------------------------------------------------------------------------
// magma_block_cipher_core
// Magma 64-bit block cipher, encrypt or decrypt, one round per pipe stage.
// ----------------------------------------------------------------------------
// The core takes one 64-bit block per clock while the pipe advances. Each of
// the 32 Feistel rounds sits in its own register stage and the last stage
// doubles as the output register, so results are offered on dst straight from
// it. The func bit rides with the block and picks the key word order at every
// stage, so encrypt and decrypt beats mix freely. When dst_ready is low with a
// result waiting, the whole pipe holds and src_ready drops; the pipe moves on
// in the same cycle the result is taken, and empty stages travel along with it
// rather than being closed up. The user must write key words through the
// config port only while no blocks are in flight; the core does not enforce
// this. Indexes above seven are ignored.
module magma_block_cipher_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [magma_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  magma_pkg::word_t                cfg_wdata,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  magma_pkg::in_t                  src_data,
    output logic                            dst_valid,
    input  logic                            dst_ready,
    output magma_pkg::out_t                 dst_data
);
    import magma_pkg::*;

    key_set_t              keys;
    logic                  adv;
    logic [NUM_ROUNDS:0]   st_vld;
    stage_t                st_data [NUM_ROUNDS+1];

    // Key storage
    magma_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .keys      (keys)
    );

    // Advance the pipe unless a finished beat is stuck at the output
    assign adv       = !st_vld[NUM_ROUNDS] || dst_ready;
    assign src_ready = adv;

    // Feed the first stage from the input beat
    assign st_vld[0]       = src_valid;
    assign st_data[0].dec  = (src_data.func == FUNC_DECRYPT);
    assign st_data[0].hi   = src_data.high_half_in;
    assign st_data[0].lo   = src_data.low_half_in;

    // Round stages
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_round
        localparam logic [KEY_IDX_W-1:0] ENC_IDX = key_index(ROUND_W'(i));
        localparam logic [KEY_IDX_W-1:0] DEC_IDX = key_index(ROUND_W'(NUM_ROUNDS - 1 - i));

        word_t rkey;

        // Pick the key word for this round from the direction bit
        assign rkey = st_data[i].dec ? keys[DEC_IDX] : keys[ENC_IDX];

        magma_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .vld_in    (st_vld[i]),
            .data_in   (st_data[i]),
            .sub_key   (rkey),
            .vld_out   (st_vld[i+1]),
            .data_out  (st_data[i+1])
        );
    end

    // Swap the halves back on the way out
    assign dst_valid              = st_vld[NUM_ROUNDS];
    assign dst_data.high_half_out = st_data[NUM_ROUNDS].lo;
    assign dst_data.low_half_out  = st_data[NUM_ROUNDS].hi;

    `MAGMA_ASSERT_IMPLY(a_stall_blocks_input, st_vld[NUM_ROUNDS] && !dst_ready, !src_ready)
    `MAGMA_ASSERT_NEXT(a_accept_enters_pipe, src_valid && src_ready, st_vld[1])
    `MAGMA_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(st_vld[NUM_ROUNDS:1]))
    `MAGMA_ASSERT_NEXT(a_last_round_reaches_out, adv && st_vld[NUM_ROUNDS-1], st_vld[NUM_ROUNDS])

endmodule

/* sim/magma_block_cipher_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_block_cipher_core_checker
// Watches the key port and both beat channels of the Magma core. It keeps
// its own copy of the key words, computes the expected block for every
// accepted input beat and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module magma_block_cipher_core_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [magma_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  magma_pkg::word_t                cfg_wdata,
    input  logic                            src_valid,
    input  logic                            src_ready,
    input  magma_pkg::in_t                  src_data,
    input  logic                            dst_valid,
    input  logic                            dst_ready,
    input  magma_pkg::out_t                 dst_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);

    import magma_pkg::*;

    // S-box rows, entry j of row n sits in nibble j
    localparam logic [7:0][63:0] SUBST_ROWS = {
        64'h2BC9_6AF4_3850_DE71,
        64'h73AD_0B4F_C196_52E8,
        64'h0E34_187B_AC29_6FD5,
        64'hC24B_E390_D618_A5F7,
        64'hB9E3_5A07_6F4D_128C,
        64'h069C_471E_DAF2_853B,
        64'hF0DB_74E1_C5A9_3286,
        64'h1F30_7D8E_9B5A_264C
    };

    word_t key_copy [NUM_KEYS];
    out_t  expected_blocks [$];

    // Run all 32 Feistel rounds on one input beat with the current key words
    function automatic out_t cipher_block(input in_t beat);
        word_t hi;
        word_t lo;
        word_t sum;
        word_t subst;
        word_t swap;
        int    rnd;
        int    idx;
        int    i;
        int    n;
        out_t  res;
        hi = beat.high_half_in;
        lo = beat.low_half_in;
        for (i = 0; i < 32; i++)
        begin
            rnd = (beat.func == FUNC_DECRYPT) ? 31 - i : i;
            // words 0..7 three times, then 7..0
            idx = (rnd < 24) ? rnd % 8 : 31 - rnd;
            sum = lo + key_copy[idx];
            for (n = 0; n < 8; n++)
            begin
                subst[4*n +: 4] = SUBST_ROWS[n][4*sum[4*n +: 4] +: 4];
            end
            subst = {subst[20:0], subst[31:21]};
            swap  = lo;
            lo    = hi ^ subst;
            hi    = swap;
        end
        // halves swap back after the last round
        res.high_half_out = lo;
        res.low_half_out  = hi;
        return res;
    endfunction

    // Track keys, queue predictions, compare output beats
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_copy[k] = '0;
            end
            expected_blocks.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (dst_valid && dst_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected output beat, expected none, actual %h_%h",
                             $time, dst_data.high_half_out, dst_data.low_half_out);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    checked++;
                    if (dst_data.high_half_out !== want.high_half_out)
                    begin
                        fail_count++;
                        $display("%0t: high_half_out mismatch, expected %h, actual %h",
                                 $time, want.high_half_out, dst_data.high_half_out);
                    end
                    if (dst_data.low_half_out !== want.low_half_out)
                    begin
                        fail_count++;
                        $display("%0t: low_half_out mismatch, expected %h, actual %h",
                                 $time, want.low_half_out, dst_data.low_half_out);
                    end
                end
            end
            // append the prediction at the tail of the queue
            if (src_valid && src_ready)
            begin
                expected_blocks.insert(expected_blocks.size(), cipher_block(src_data));
            end
            // indexes above seven are dropped
            if (cfg_wr_en && cfg_addr < NUM_KEYS)
            begin
                key_copy[cfg_addr[KEY_IDX_W-1:0]] = cfg_wdata;
            end
            pending = expected_blocks.size();
        end
    end

endmodule

/* sim/magma_block_cipher_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_block_cipher_core_tb
// Drives the Magma core with directed and random encrypt/decrypt beats
// under several key settings and idle patterns; the checker scores results.
// ----------------------------------------------------------------------------
module magma_block_cipher_core_tb;

    import magma_pkg::*;

    localparam int PHASE_BLOCKS = 250;
    localparam int NUM_PHASES   = 6;
    localparam int STALL_CYCLES = 200;
    localparam int WATCHDOG_MAX = 5000;
    localparam int DRAIN_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    word_t                cfg_wdata;
    logic                 src_valid;
    logic                 src_ready;
    in_t                  src_data;
    logic                 dst_valid;
    logic                 dst_ready;
    out_t                 dst_data;

    int fail_count;
    int pending;
    int checked;

    int   src_idle_pct;
    int   dst_idle_pct;
    logic hold_req;
    int   hold_left;
    int   stall_count;
    int   blocks_sent;
    int   decrypt_sent;
    int   key_loads;

    magma_block_cipher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    magma_block_cipher_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_data   (src_data),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_data   (dst_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver: random back-pressure, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            dst_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = STALL_CYCLES - 1;
            dst_ready <= 1'b0;
        end
        else
        begin
            dst_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && src_ready) || (dst_valid && dst_ready) || cfg_wr_en)
        begin
            stall_count <= 0;
        end
        else if (stall_count >= WATCHDOG_MAX)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_MAX);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

    // Mostly random words, with a share of all-zero, all-one, one-hot and one-cold values
    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = word_t'(1) << $urandom_range(31);
            3: w = ~(word_t'(1) << $urandom_range(31));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Offer one beat after a random idle gap; return at the next falling edge
    task automatic offer_block(input logic func, input word_t hi, input word_t lo);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid              <= 1'b1;
        src_data.func          <= func;
        src_data.high_half_in  <= hi;
        src_data.low_half_in   <= lo;
        @(posedge clk);
        while (!src_ready)
        begin
            @(posedge clk);
        end
        blocks_sent++;
        if (func == FUNC_DECRYPT)
        begin
            decrypt_sent++;
        end
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected block has come out
    task automatic drain_blocks();
        src_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Write all eight key words, then one write to an unused index
    task automatic load_keys(input key_set_t kw);
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= kw[i];
            @(negedge clk);
        end
        cfg_addr  <= CFG_IDX_W'(NUM_KEYS + $urandom_range(NUM_KEYS - 1));
        cfg_wdata <= $urandom;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        key_loads++;
    endtask

    // Stimulus
    initial
    begin
        key_set_t keys;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        src_valid    = 1'b0;
        src_data     = '0;
        dst_ready    = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        stall_count  = 0;
        blocks_sent  = 0;
        decrypt_sent = 0;
        key_loads    = 0;
        src_idle_pct = 18;
        dst_idle_pct = 72;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset key: all words zero
        offer_block(1'b0, 32'h0000_0000, 32'h0000_0000);
        offer_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_blocks();

        // Standard test key, known vector and its inverse, field extremes
        keys[0] = 32'hFFEE_DDCC;
        keys[1] = 32'hBBAA_9988;
        keys[2] = 32'h7766_5544;
        keys[3] = 32'h3322_1100;
        keys[4] = 32'hF0F1_F2F3;
        keys[5] = 32'hF4F5_F6F7;
        keys[6] = 32'hF8F9_FAFB;
        keys[7] = 32'hFCFD_FEFF;
        load_keys(keys);
        offer_block(1'b0, 32'hFEDC_BA98, 32'h7654_3210);
        offer_block(FUNC_DECRYPT, 32'h4EE9_01E5, 32'hC2D8_CA3D);
        offer_block(1'b0, 32'h0000_0000, 32'h0000_0000);
        offer_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_block(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
        offer_block(FUNC_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        offer_block(1'b0, 32'h0000_0001, 32'h0000_0000);
        offer_block(1'b0, 32'h0000_0000, 32'h0000_0001);
        offer_block(1'b0, 32'h8000_0000, 32'h0000_0000);
        offer_block(FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        drain_blocks();

        // Random phases, each under its own key setting and one of three idle patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: keys = '1;
                2: keys = '0;
                4:
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        keys[k] = (k % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555;
                    end
                end
                default:
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        keys[k] = pick_word();
                    end
                end
            endcase
            load_keys(keys);
            case (p % 3)
                0:
                begin
                    src_idle_pct = 18;
                    dst_idle_pct = 72;
                end
                1:
                begin
                    src_idle_pct = 72;
                    dst_idle_pct = 18;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                // long receiver hold while the sender keeps offering
                if (n == 120 && p % 3 != 1)
                begin
                    hold_req = 1'b1;
                end
                // pause the sender until the pipe is empty
                if (n == 125 && p % 3 == 1)
                begin
                    drain_blocks();
                end
                offer_block(1'($urandom_range(1)), pick_word(), pick_word());
            end
            drain_blocks();
        end

        // Let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d blocks (%0d decrypt) under %0d key settings, three idle patterns,",
                 blocks_sent, decrypt_sent, key_loads + 1);
        $display("long output stalls and drain pauses; %0d results compared, %0d mismatches.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/magma_pkg.sv
hdl/magma_key_regs.sv
hdl/magma_round.sv
hdl/magma_block_cipher_core.sv
sim/magma_block_cipher_core_checker.sv
sim/magma_block_cipher_core_tb.sv
